### sv/rca_pkg.sv
// Shared constants and types for the ratio chi-square accumulator.
`timescale 1ns / 1ps

package rca_pkg;

  // Bin count limit: the smaller of the bin ceiling and the 17-bit counter range.
  localparam int unsigned MaxBins     = 65536;
  localparam int unsigned CountW      = 17;
  localparam int unsigned CountTop    = (1 << CountW) - 1;
  localparam int unsigned CountCapInt = (MaxBins < CountTop) ? MaxBins : CountTop;
  localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);

  localparam int unsigned ValW = 48;            // Q32.16 values and sums
  localparam logic [ValW-1:0] ValMax = '1;
  localparam logic [ValW-1:0] OneQ16 = ValW'(65536);

  localparam int unsigned AccW = 96;            // shared unit accumulator
  localparam int unsigned SumW = AccW + 2;      // shared adder width
  localparam int unsigned CntW = 7;             // step counter, up to AccW steps

  localparam logic [3:0] NParamReset = 4'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PD,
    ST_PM,
    ST_VD,
    ST_VM,
    ST_F,
    ST_ED2,
    ST_EM2,
    ST_E2,
    ST_FF,
    ST_VR,
    ST_DSQ,
    ST_TERM,
    ST_CHI,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    UM_MUL,
    UM_DIV,
    UM_ADD
  } unit_mode_e;

  typedef struct packed {
    unit_mode_e            mode;
    logic                  keep_acc;
    logic [AccW-1:0]       acc;
    logic [AccW-1:0]       a;
    logic [AccW-1:0]       b;
    logic [CntW-1:0]       steps;
  } unit_op_t;

endpackage

### sv/ratio_chi_square_accumulator.sv
// Top level of the ratio chi-square accumulator: sequencer and shared shift-add/subtract unit.
`timescale 1ns / 1ps

// Takes one correlation bin per input transfer and returns one result transfer per bin.
// A bin with either raw count zero is passed through as not counted. A counted bin first
// forms both error products and their squares; if either product is zero it stops there,
// otherwise it goes on to the ratio f = dd/mm, the ratio variance
// (err_dd^2 + err_mm^2) * f^2, the term (f-1)^2 / variance and the running chi-square.
// Every multiply is MSB-first shift-and-add and every divide restoring shift-subtract,
// one bit per cycle through a single 98-bit adder; the number of steps of each multiply
// and divide is set by the operand widths (24, 56, 48, 49 and 96 steps). The input is not
// ready while a bin is in work; the result register lets the next bin be taken while
// the previous result still waits. Values are Q32.16 and clip at 2^48-1, setting the
// saturated flag, which stays set until the result marked last_result; after that
// result the chi-square, bin count and flag return to zero. The fitted-parameter count
// is written through cfg_we_i/cfg_wdata_i; the user must write it only while the block
// is idle, which the block itself does not enforce. Its reset value is 2.
module ratio_chi_square_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  // bin input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        data_raw_count_i,
  input  logic [31:0]        model_raw_count_i,
  input  logic [31:0]        data_weighted_i,
  input  logic [31:0]        model_weighted_i,
  input  logic [23:0]        data_frac_error_i,
  input  logic [23:0]        model_frac_error_i,
  input  logic               last_bin_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               bin_counted_o,
  output logic               bin_used_o,
  output logic [47:0]        data_variance_o,
  output logic [47:0]        model_variance_o,
  output logic [47:0]        ratio_variance_o,
  output logic [47:0]        bin_term_o,
  output logic [47:0]        chi_total_o,
  output logic signed [17:0] dof_total_o,
  output logic               last_result_o,
  output logic               saturated_o
);

  import rca_pkg::*;

  // sequencer
  state_e state_q, state_d;
  logic   run_q;
  logic [CntW-1:0] cnt_q;
  logic   op_setup, op_done, in_xfer, out_free, counted_in;

  // shared unit
  unit_mode_e      mode_q;
  unit_op_t        op;
  logic [AccW-1:0] acc_q, a_q, b_q;
  logic            ovf_q;
  logic [SumW-1:0] add_x, add_y, add_sum;
  logic            add_cin, q_bit;
  logic [ValW-1:0] mul_res;

  // current bin
  logic [31:0]     dd_q, mm_q;
  logic [23:0]     ed_q, em_q;
  logic            last_q, counted_q, used_q, sat_q;
  logic [55:0]     pd_q, pm_q;
  logic [ValW-1:0] var_d_q, var_m_q, var_r_q, term_q, f_q, dev;
  logic [ValW:0]   e2_q;

  // running totals and configuration
  logic [ValW-1:0]   chi_q;
  logic [CountW-1:0] bins_q;
  logic              satflag_q;
  logic [3:0]        nparam_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign counted_in = (data_raw_count_i != '0) && (model_raw_count_i != '0);
  assign out_free   = !out_valid_o || out_ready_i;
  assign op_setup   = !run_q && (state_q != ST_IDLE) && (state_q != ST_DONE);
  assign op_done    = run_q && (cnt_q == '0);

  // |f - 1.0|
  assign dev = (f_q >= OneQ16) ? (f_q - OneQ16) : (OneQ16 - f_q);

  // Q.64 product back to Q.16, clipped when the product reached 2^96
  assign mul_res = ovf_q ? ValMax : acc_q[AccW-1:AccW-ValW];

  // ---------------------------------------------------------------------------------------
  // Shared adder: MSB-first multiply step, restoring divide step, or plain add.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    case (mode_q)
      UM_MUL: begin
        add_x = {1'b0, acc_q, 1'b0};
        add_y = b_q[AccW-1] ? {2'b00, a_q} : '0;
      end
      UM_DIV: begin
        add_x   = {{(SumW-ValW-1){1'b0}}, acc_q[ValW-1:0], b_q[AccW-1]};
        add_y   = ~{{(SumW-ValW){1'b0}}, a_q[ValW-1:0]};
        add_cin = 1'b1;
      end
      UM_ADD: begin
        add_x = {2'b00, acc_q};
        add_y = {2'b00, a_q};
      end
      default: ;
    endcase
  end

  assign add_sum = add_x + add_y + {{(SumW-1){1'b0}}, add_cin};
  assign q_bit   = !add_sum[SumW-1];

  // ---------------------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = counted_in ? ST_PD : ST_DONE;
      end
      ST_PD:   if (op_done) state_d = ST_PM;
      ST_PM:   if (op_done) state_d = ST_VD;
      ST_VD:   if (op_done) state_d = ST_VM;
      ST_VM: if (op_done) begin
        // zero error product: variances only, no term
        state_d = ((pd_q == '0) || (pm_q == '0)) ? ST_DONE : ST_F;
      end
      ST_F:    if (op_done) state_d = ST_ED2;
      ST_ED2:  if (op_done) state_d = ST_EM2;
      ST_EM2:  if (op_done) state_d = ST_E2;
      ST_E2:   if (op_done) state_d = ST_FF;
      ST_FF:   if (op_done) state_d = ST_VR;
      ST_VR: if (op_done) begin
        // term settled without division when f is 1.0 or the variance truncated to zero
        state_d = ((dev == '0) || (mul_res == '0)) ? ST_CHI : ST_DSQ;
      end
      ST_DSQ:  if (op_done) state_d = ST_TERM;
      ST_TERM: if (op_done) state_d = ST_CHI;
      ST_CHI:  if (op_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Operand set-up for each step of the sequence
  // ---------------------------------------------------------------------------------------
  always_comb begin
    op          = '0;
    op.mode     = UM_MUL;
    op.keep_acc = 1'b0;
    case (state_q)
      ST_PD: begin
        op.a     = {{(AccW-32){1'b0}}, dd_q};
        op.b     = {ed_q, {(AccW-24){1'b0}}};
        op.steps = CntW'(24);
      end
      ST_PM: begin
        op.a     = {{(AccW-32){1'b0}}, mm_q};
        op.b     = {em_q, {(AccW-24){1'b0}}};
        op.steps = CntW'(24);
      end
      ST_VD: begin
        op.a     = {{(AccW-56){1'b0}}, pd_q};
        op.b     = {pd_q, {(AccW-56){1'b0}}};
        op.steps = CntW'(56);
      end
      ST_VM: begin
        op.a     = {{(AccW-56){1'b0}}, pm_q};
        op.b     = {pm_q, {(AccW-56){1'b0}}};
        op.steps = CntW'(56);
      end
      ST_F: begin
        // (dd << 16) / mm, 48-bit dividend left-aligned
        op.mode  = UM_DIV;
        op.a     = {{(AccW-32){1'b0}}, mm_q};
        op.b     = {dd_q, {(AccW-32){1'b0}}};
        op.steps = CntW'(ValW);
      end
      ST_ED2: begin
        op.a     = {{(AccW-24){1'b0}}, ed_q};
        op.b     = {ed_q, {(AccW-24){1'b0}}};
        op.steps = CntW'(24);
      end
      ST_EM2: begin
        op.a     = {{(AccW-24){1'b0}}, em_q};
        op.b     = {em_q, {(AccW-24){1'b0}}};
        op.steps = CntW'(24);
      end
      ST_E2: begin
        op.mode     = UM_ADD;
        op.keep_acc = 1'b1;
        op.a        = {{(AccW-ValW-1){1'b0}}, e2_q};
        op.steps    = CntW'(1);
      end
      ST_FF: begin
        op.a     = {{(AccW-ValW){1'b0}}, f_q};
        op.b     = {f_q, {(AccW-ValW){1'b0}}};
        op.steps = CntW'(ValW);
      end
      ST_VR: begin
        // f^2 (still in the accumulator) times e2
        op.a     = acc_q;
        op.b     = {e2_q, {(AccW-ValW-1){1'b0}}};
        op.steps = CntW'(ValW + 1);
      end
      ST_DSQ: begin
        op.a     = {{(AccW-ValW){1'b0}}, dev};
        op.b     = {dev, {(AccW-ValW){1'b0}}};
        op.steps = CntW'(ValW);
      end
      ST_TERM: begin
        // (f-1)^2 (still in the accumulator) over the ratio variance
        op.mode  = UM_DIV;
        op.a     = {{(AccW-ValW){1'b0}}, var_r_q};
        op.b     = acc_q;
        op.steps = CntW'(AccW);
      end
      ST_CHI: begin
        op.mode  = UM_ADD;
        op.acc   = {{(AccW-ValW){1'b0}}, chi_q};
        op.a     = {{(AccW-ValW){1'b0}}, term_q};
        op.steps = CntW'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Control registers and running totals
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      chi_q       <= '0;
      bins_q      <= '0;
      satflag_q   <= 1'b0;
      nparam_q    <= NParamReset;
    end else begin
      state_q <= state_d;

      if (op_setup) begin
        run_q <= 1'b1;
        cnt_q <= op.steps;
      end else if (op_done) begin
        run_q <= 1'b0;
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
      end

      if (cfg_we_i) begin
        nparam_q <= cfg_wdata_i;
      end

      if (in_xfer && counted_in && (bins_q < CountCap)) begin
        bins_q <= bins_q + CountW'(1);
      end

      if (op_done && (state_q == ST_CHI)) begin
        chi_q <= acc_q[ValW] ? ValMax : acc_q[ValW-1:0];
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_o <= 1'b1;
        if (last_q) begin
          chi_q     <= '0;
          bins_q    <= '0;
          satflag_q <= 1'b0;
        end else begin
          satflag_q <= satflag_q | sat_q;
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // shared unit
    if (op_setup) begin
      mode_q <= op.mode;
      a_q    <= op.a;
      b_q    <= op.b;
      ovf_q  <= 1'b0;
      if (!op.keep_acc) acc_q <= op.acc;
    end else if (run_q && (cnt_q != '0)) begin
      case (mode_q)
        UM_MUL: begin
          acc_q <= add_sum[AccW-1:0];
          b_q   <= {b_q[AccW-2:0], 1'b0};
          if (add_sum[SumW-1:AccW] != '0) ovf_q <= 1'b1;
        end
        UM_DIV: begin
          acc_q <= {{(AccW-ValW){1'b0}}, q_bit ? add_sum[ValW-1:0] : add_x[ValW-1:0]};
          b_q   <= {b_q[AccW-2:0], q_bit};
          // a quotient bit landing above bit 47
          if (q_bit && (cnt_q > CntW'(ValW))) ovf_q <= 1'b1;
        end
        UM_ADD: begin
          acc_q <= add_sum[AccW-1:0];
        end
        default: ;
      endcase
    end

    // bin capture
    if (in_xfer) begin
      dd_q      <= data_weighted_i;
      mm_q      <= model_weighted_i;
      ed_q      <= data_frac_error_i;
      em_q      <= model_frac_error_i;
      last_q    <= last_bin_i;
      counted_q <= counted_in;
      used_q    <= 1'b0;
      sat_q     <= counted_in && (bins_q >= CountCap);
      var_d_q   <= '0;
      var_m_q   <= '0;
      var_r_q   <= '0;
      term_q    <= '0;
    end

    // results of each operation
    if (op_done) begin
      case (state_q)
        ST_PD: pd_q <= acc_q[55:0];
        ST_PM: pm_q <= acc_q[55:0];
        ST_VD: begin
          var_d_q <= mul_res;
          if (ovf_q) sat_q <= 1'b1;
        end
        ST_VM: begin
          var_m_q <= mul_res;
          if (ovf_q) sat_q <= 1'b1;
        end
        ST_F:   f_q  <= b_q[ValW-1:0];
        ST_ED2: e2_q <= acc_q[ValW:0];
        ST_E2:  e2_q <= acc_q[ValW:0];
        ST_VR: begin
          var_r_q <= mul_res;
          if (ovf_q) sat_q <= 1'b1;
          if ((dev != '0) && (mul_res == '0)) begin
            term_q <= ValMax;
            sat_q  <= 1'b1;
          end
        end
        ST_TERM: begin
          term_q <= ovf_q ? ValMax : b_q[ValW-1:0];
          if (ovf_q) sat_q <= 1'b1;
        end
        ST_CHI: begin
          used_q <= 1'b1;
          if (acc_q[ValW]) sat_q <= 1'b1;
        end
        default: ;
      endcase
    end

    // result register
    if (state_q == ST_DONE && out_free) begin
      bin_counted_o    <= counted_q;
      bin_used_o       <= used_q;
      data_variance_o  <= var_d_q;
      model_variance_o <= var_m_q;
      ratio_variance_o <= var_r_q;
      bin_term_o       <= term_q;
      chi_total_o      <= chi_q;
      dof_total_o      <= {1'b0, bins_q} - {{(CountW-3){1'b0}}, nparam_q};
      last_result_o    <= last_q;
      saturated_o      <= satflag_q | sat_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input ready straight after a bin was taken");

  a_skipped_bin_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bin_counted_o |->
      !bin_used_o && (bin_term_o == '0) && (data_variance_o == '0) &&
      (ratio_variance_o == '0))
    else $error("uncounted bin carries a term or variance");

  a_totals_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_free && last_q |=>
      (chi_q == '0) && (bins_q == '0) && !satflag_q)
    else $error("totals not cleared after the last bin");

endmodule
